// File: rtl/lgt_pkg.sv
// ----------------------------------------------------------------------------
// lgt_pkg
// Shared types, constants and the sine table builder of the leg gait
// trajectory generator.
// ----------------------------------------------------------------------------
package lgt_pkg;

    // Sizes
    localparam int SINE_ENTRIES    = 1024;
    localparam int SINE_AW         = $clog2(SINE_ENTRIES);
    localparam int MAX_STEPS       = 1024;
    localparam int ANGLE_FRAC_BITS = 12;
    localparam int SINE_FRAC       = 14;
    localparam int STEP_W          = 10;
    localparam int CYC_W           = 11;
    localparam int ACC_W           = 20;
    localparam int DIV_W           = STEP_W + SINE_AW;
    localparam int DIV_CNT_W       = $clog2(DIV_W);
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 48;

    localparam logic [CYC_W-1:0]   MAX_CYCLE = CYC_W'(MAX_STEPS);
    localparam logic [SINE_AW-1:0] QUARTER   = SINE_AW'(SINE_ENTRIES / 4);

    // Operation codes
    localparam logic [2:0] OP_FWD    = 3'd0;
    localparam logic [2:0] OP_BACK   = 3'd1;
    localparam logic [2:0] OP_STANCE = 3'd2;
    localparam logic [2:0] OP_ZERO   = 3'd3;
    localparam logic [2:0] OP_EVAL   = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SIDE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STANCE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SINE_AMP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRA_AMP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WALK_LO    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WALK_HI    = 3'd6;

    // Multiply slots: operand pair and destination
    localparam logic [2:0] MUL_ABD_S  = 3'd0;  // hip abduction amp * sin
    localparam logic [2:0] MUL_FLX_S  = 3'd1;  // hip flexion amp * sin
    localparam logic [2:0] MUL_FLX_C  = 3'd2;  // hip flexion cos amp * cos
    localparam logic [2:0] MUL_KNE_S  = 3'd3;  // knee amp * sin
    localparam logic [2:0] MUL_BUMP   = 3'd4;  // sin * sin
    localparam logic [2:0] MUL_KNE_B  = 3'd5;  // knee lift * bump
    localparam logic [2:0] MUL_LAST   = MUL_KNE_B;

    // Mechanical limits, Q3.12
    localparam int MQ_300  = (300  * (1 << ANGLE_FRAC_BITS) + 500) / 1000;
    localparam int MQ_600  = (600  * (1 << ANGLE_FRAC_BITS) + 500) / 1000;
    localparam int MQ_1400 = (1400 * (1 << ANGLE_FRAC_BITS) + 500) / 1000;
    localparam int MQ_2260 = (2260 * (1 << ANGLE_FRAC_BITS) + 500) / 1000;

    typedef logic signed [15:0] joint3_t [3];

    localparam joint3_t MECH_LO_LEFT  = '{16'(-MQ_300), 16'(-MQ_600), 16'(-MQ_2260)};
    localparam joint3_t MECH_HI_LEFT  = '{16'(MQ_300), 16'(MQ_1400), 16'sd0};
    localparam joint3_t MECH_LO_RIGHT = '{16'(-MQ_300), 16'(-MQ_1400), 16'sd0};
    localparam joint3_t MECH_HI_RIGHT = '{16'(MQ_300), 16'(MQ_600), 16'(MQ_2260)};

    // Configuration image
    typedef struct packed {
        logic              right_side;
        logic [CYC_W-1:0]  total_steps;
        logic [47:0]       stance_angles;
        logic [47:0]       sine_amplitudes;
        logic [31:0]       extra_amplitudes;
        logic [47:0]       walk_low_limits;
        logic [47:0]       walk_high_limits;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       init_stance;
        logic       init_zero;
        logic       cnt_clear;
        logic       cnt_back;
        logic       cnt_from_rem;
        logic       div_start_cnt;
        logic       div_start_phase;
        logic       div_step;
        logic       rom_sin;
        logic       rom_cos;
        logic       cap_sin;
        logic       cap_cos;
        logic       mul;
        logic       acc;
        logic [2:0] mul_sel;
        logic       walk;
        logic       mech;
        logic       out_load;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] op;
        logic       cyc_zero;
        logic       out_free;
    } dp_status_t;

    // Sine table, signed Q1.14, built at elaboration from a Taylor series
    typedef logic signed [15:0] sine_rom_t [SINE_ENTRIES];

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    typedef longint unsigned div7_t [7];
    localparam div7_t SIN_DIV = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};
    localparam div7_t COS_DIV = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182};

    function automatic logic signed [15:0] sine_entry(int unsigned k);
        longint unsigned t, quad, r, x, x2, ts, tc;
        longint ss, cs, mag, q;
        t    = 64'(k % SINE_ENTRIES) * 64'd4;
        quad = t / SINE_ENTRIES;
        r    = t % SINE_ENTRIES;
        x    = HALF_PI_Q30 * r / SINE_ENTRIES;
        x2   = (x * x) >> 30;
        ts   = x;
        tc   = 64'd1 << 30;
        ss   = longint'(ts);
        cs   = longint'(tc);
        for (int n = 0; n < 7; n++) begin
            ts = ((ts * x2) >> 30) / SIN_DIV[n];
            tc = ((tc * x2) >> 30) / COS_DIV[n];
            if (n[0] == 1'b0) begin
                ss = ss - longint'(ts);
                cs = cs - longint'(tc);
            end else begin
                ss = ss + longint'(ts);
                cs = cs + longint'(tc);
            end
        end
        mag = quad[0] ? cs : ss;
        if (mag < 0) mag = 0;
        q = longint'((unsigned'(mag) + 64'd32768) >> 16);
        if (q > 16384) q = 16384;
        return (quad >= 64'd2) ? 16'(-q) : 16'(q);
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            rom[k] = sine_entry(k);
        end
        return rom;
    endfunction

endpackage

// File: rtl/lgt_cfg_regs.sv
// ----------------------------------------------------------------------------
// lgt_cfg_regs
// Configuration register file, written through the cfg write channel.
// ----------------------------------------------------------------------------
module lgt_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lgt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lgt_pkg::CFG_DATA_W-1:0]  cfg_data,
    output lgt_pkg::cfg_t                   cfg
);
    import lgt_pkg::*;

    cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_RIGHT_SIDE: cfg_next.right_side       = cfg_data[0];
                REG_TOTAL:      cfg_next.total_steps      = cfg_data[CYC_W-1:0];
                REG_STANCE:     cfg_next.stance_angles    = cfg_data[47:0];
                REG_SINE_AMP:   cfg_next.sine_amplitudes  = cfg_data[47:0];
                REG_EXTRA_AMP:  cfg_next.extra_amplitudes = cfg_data[31:0];
                REG_WALK_LO:    cfg_next.walk_low_limits  = cfg_data[47:0];
                REG_WALK_HI:    cfg_next.walk_high_limits = cfg_data[47:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/lgt_ctrl.sv
// ----------------------------------------------------------------------------
// lgt_ctrl
// Sequencer: walks the datapath through counter update, phase division,
// table reads, the shared multiply slots and the two clamps.
// ----------------------------------------------------------------------------
module lgt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  lgt_pkg::dp_status_t  status,
    output lgt_pkg::dp_cmd_t     cmd
);
    import lgt_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_FDIV   = 4'd2;
    localparam logic [3:0] ST_FCAP   = 4'd3;
    localparam logic [3:0] ST_PSTART = 4'd4;
    localparam logic [3:0] ST_PDIV   = 4'd5;
    localparam logic [3:0] ST_ROMS   = 4'd6;
    localparam logic [3:0] ST_ROMC   = 4'd7;
    localparam logic [3:0] ST_CAPC   = 4'd8;
    localparam logic [3:0] ST_MUL    = 4'd9;
    localparam logic [3:0] ST_ACC    = 4'd10;
    localparam logic [3:0] ST_WALK   = 4'd11;
    localparam logic [3:0] ST_MECH   = 4'd12;
    localparam logic [3:0] ST_DONE   = 4'd13;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

    logic [3:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] iter_reg, iter_next;
    logic [2:0]           slot_reg, slot_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        slot_next  = slot_reg;
        cmd        = '0;
        cmd.mul_sel = slot_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                iter_next = '0;
                if ((status.op == OP_FWD || status.op == OP_BACK) && status.cyc_zero) begin
                    cmd.cnt_clear   = 1'b1;
                    cmd.init_stance = 1'b1;
                    state_next      = ST_MECH;
                end else if (status.op == OP_FWD) begin
                    cmd.div_start_cnt = 1'b1;
                    state_next        = ST_FDIV;
                end else if (status.op == OP_BACK) begin
                    cmd.cnt_back = 1'b1;
                    state_next   = ST_PSTART;
                end else if (status.op == OP_EVAL) begin
                    if (status.cyc_zero) begin
                        cmd.init_stance = 1'b1;
                        state_next      = ST_MECH;
                    end else begin
                        state_next = ST_PSTART;
                    end
                end else if (status.op == OP_STANCE) begin
                    cmd.init_stance = 1'b1;
                    state_next      = ST_WALK;
                end else if (status.op == OP_ZERO) begin
                    cmd.init_zero = 1'b1;
                    state_next    = ST_MECH;
                end else begin
                    cmd.init_zero = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_FDIV: begin
                cmd.div_step = 1'b1;
                iter_next    = iter_reg + 1'b1;
                if (iter_reg == DIV_LAST) state_next = ST_FCAP;
            end
            ST_FCAP: begin
                cmd.cnt_from_rem = 1'b1;
                state_next       = ST_PSTART;
            end
            ST_PSTART: begin
                cmd.div_start_phase = 1'b1;
                cmd.init_stance     = 1'b1;
                iter_next           = '0;
                state_next          = ST_PDIV;
            end
            ST_PDIV: begin
                cmd.div_step = 1'b1;
                iter_next    = iter_reg + 1'b1;
                if (iter_reg == DIV_LAST) state_next = ST_ROMS;
            end
            ST_ROMS: begin
                cmd.rom_sin = 1'b1;
                state_next  = ST_ROMC;
            end
            ST_ROMC: begin
                cmd.rom_cos = 1'b1;
                cmd.cap_sin = 1'b1;
                state_next  = ST_CAPC;
            end
            ST_CAPC: begin
                cmd.cap_cos = 1'b1;
                slot_next   = MUL_ABD_S;
                state_next  = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
                if (slot_reg == MUL_LAST) begin
                    state_next = ST_WALK;
                end else begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_WALK: begin
                cmd.walk   = 1'b1;
                state_next = ST_MECH;
            end
            ST_MECH: begin
                cmd.mech   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
            slot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

// File: rtl/lgt_datapath.sv
// ----------------------------------------------------------------------------
// lgt_datapath
// Gait counter, restoring divider, sine ROM, shared multiplier with
// accumulators, walking and mechanical clamps, and the result register.
// ----------------------------------------------------------------------------
module lgt_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  lgt_pkg::cfg_t       cfg,
    input  lgt_pkg::dp_cmd_t    cmd,
    output lgt_pkg::dp_status_t status,
    input  logic [2:0]          in_op,
    input  logic [9:0]          in_gait_index,
    input  logic                in_forward,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [63:0]         m_tdata     // hip_abd 15:0, hip_flx 31:16, knee 47:32,
                                            // step_position 57:48, mech_clipped 60:58
);
    import lgt_pkg::*;

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // Latched command
    logic [2:0]         op_reg;
    logic [STEP_W-1:0]  idx_reg;
    logic               fwd_reg;
    logic [CYC_W-1:0]   cyc_reg;

    logic [STEP_W-1:0]  cnt_reg;
    logic [DIV_W-1:0]   num_reg;
    logic [CYC_W-1:0]   rem_reg;

    logic signed [15:0]     rom_q_reg, sin_reg, cos_reg, bump_reg;
    logic signed [31:0]     prod_reg;
    logic signed [ACC_W-1:0] acc_reg [3];
    logic [2:0]             clip_reg;

    logic               m_valid_reg;
    logic [63:0]        m_data_reg;

    logic [SINE_AW-1:0] rom_addr;
    logic [CYC_W:0]     rem_sh;
    logic               rem_ge;
    logic [STEP_W-1:0]  phase_step;
    logic signed [15:0] mul_a, mul_b;
    logic signed [32:0] prod_rnd;
    logic signed [ACC_W-1:0] term, term_sgn;

    assign status.op       = op_reg;
    assign status.cyc_zero = (cyc_reg == '0);
    assign status.out_free = !m_valid_reg || m_tready;
    assign m_tvalid        = m_valid_reg;
    assign m_tdata         = m_data_reg;

    // Divider step, table address, multiplier operands, rounding
    assign rem_sh     = {rem_reg, num_reg[DIV_W-1]};
    assign rem_ge     = (rem_sh >= {1'b0, cyc_reg});
    assign phase_step = (op_reg == OP_EVAL) ? idx_reg : cnt_reg;
    assign rom_addr   = cmd.rom_cos ? num_reg[SINE_AW-1:0] + QUARTER
                                    : num_reg[SINE_AW-1:0];

    always_comb begin
        case (cmd.mul_sel)
            MUL_ABD_S: begin mul_a = signed'(cfg.sine_amplitudes[15:0]);  mul_b = sin_reg; end
            MUL_FLX_S: begin mul_a = signed'(cfg.sine_amplitudes[31:16]); mul_b = sin_reg; end
            MUL_FLX_C: begin mul_a = signed'(cfg.extra_amplitudes[15:0]); mul_b = cos_reg; end
            MUL_KNE_S: begin mul_a = signed'(cfg.sine_amplitudes[47:32]); mul_b = sin_reg; end
            MUL_BUMP:  begin mul_a = sin_reg;                             mul_b = sin_reg; end
            default:   begin mul_a = signed'(cfg.extra_amplitudes[31:16]); mul_b = bump_reg; end
        endcase
    end

    assign prod_rnd = 33'(prod_reg) + 33'sd8192;
    assign term     = ACC_W'(prod_rnd >>> SINE_FRAC);
    assign term_sgn = cfg.right_side ? -term : term;

    // ROM read
    always_ff @(posedge aclk) begin
        if (cmd.rom_sin || cmd.rom_cos) rom_q_reg <= SINE_ROM[rom_addr];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.cnt_clear) begin
                cnt_reg <= '0;
            end else if (cmd.cnt_back) begin
                cnt_reg <= (cnt_reg == '0) ? STEP_W'(cyc_reg - 1'b1) : cnt_reg - 1'b1;
            end else if (cmd.cnt_from_rem) begin
                cnt_reg <= rem_reg[STEP_W-1:0];
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= in_op;
            idx_reg <= in_gait_index;
            fwd_reg <= (in_op == OP_FWD) ? 1'b1 : (in_op == OP_BACK) ? 1'b0 : in_forward;
            cyc_reg <= (cfg.total_steps > MAX_CYCLE) ? MAX_CYCLE : cfg.total_steps;
        end

        // divider
        if (cmd.div_start_cnt) begin
            num_reg <= DIV_W'({1'b0, cnt_reg} + 1'b1);
            rem_reg <= '0;
        end else if (cmd.div_start_phase) begin
            num_reg <= {phase_step, {SINE_AW{1'b0}}};
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            num_reg <= {num_reg[DIV_W-2:0], rem_ge};
            rem_reg <= rem_ge ? CYC_W'(rem_sh - {1'b0, cyc_reg}) : rem_sh[CYC_W-1:0];
        end

        // sine and cosine, negated for backward motion
        if (cmd.cap_sin) sin_reg <= fwd_reg ? rom_q_reg : -rom_q_reg;
        if (cmd.cap_cos) cos_reg <= fwd_reg ? rom_q_reg : -rom_q_reg;

        if (cmd.mul) prod_reg <= mul_a * mul_b;

        // accumulators
        if (cmd.init_stance) begin
            for (int j = 0; j < 3; j++) begin
                acc_reg[j] <= ACC_W'(signed'(cfg.stance_angles[16*j +: 16]));
            end
            clip_reg <= '0;
        end else if (cmd.init_zero) begin
            for (int j = 0; j < 3; j++) acc_reg[j] <= '0;
            clip_reg <= '0;
        end else if (cmd.acc) begin
            case (cmd.mul_sel) inside
                MUL_ABD_S:            acc_reg[0] <= acc_reg[0] + term;
                MUL_FLX_S, MUL_FLX_C: acc_reg[1] <= acc_reg[1] + term_sgn;
                MUL_BUMP:             bump_reg <= (sin_reg > 0) ? term[15:0] : 16'sd0;
                default:              acc_reg[2] <= acc_reg[2] + term_sgn;
            endcase
        end else if (cmd.walk) begin
            for (int j = 0; j < 3; j++) begin
                if (acc_reg[j] < ACC_W'(signed'(cfg.walk_low_limits[16*j +: 16]))) begin
                    acc_reg[j] <= ACC_W'(signed'(cfg.walk_low_limits[16*j +: 16]));
                end else if (acc_reg[j] > ACC_W'(signed'(cfg.walk_high_limits[16*j +: 16]))) begin
                    acc_reg[j] <= ACC_W'(signed'(cfg.walk_high_limits[16*j +: 16]));
                end
            end
        end else if (cmd.mech) begin
            for (int j = 0; j < 3; j++) begin
                if (acc_reg[j] < ACC_W'(cfg.right_side ? MECH_LO_RIGHT[j] : MECH_LO_LEFT[j])) begin
                    acc_reg[j]  <= ACC_W'(cfg.right_side ? MECH_LO_RIGHT[j] : MECH_LO_LEFT[j]);
                    clip_reg[j] <= 1'b1;
                end else if (acc_reg[j] >
                             ACC_W'(cfg.right_side ? MECH_HI_RIGHT[j] : MECH_HI_LEFT[j])) begin
                    acc_reg[j]  <= ACC_W'(cfg.right_side ? MECH_HI_RIGHT[j] : MECH_HI_LEFT[j]);
                    clip_reg[j] <= 1'b1;
                end
            end
        end

        // result register
        if (cmd.out_load) begin
            m_data_reg <= {3'b000, clip_reg, cnt_reg, acc_reg[2][15:0],
                           acc_reg[1][15:0], acc_reg[0][15:0]};
        end
    end

endmodule

// File: rtl/leg_gait_trajectory_generator.sv
// ----------------------------------------------------------------------------
// leg_gait_trajectory_generator
// Joint angle targets for one leg from gait commands.
//
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    tuser: operation; tdata: gait_index, forward
// m_        out  m_tvalid/m_tready    tdata: three angles, step_position, mech_clipped
// cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One command at a time. A forward step runs the counter modulo and then the
// phase division on the bit-serial divider; backward and evaluate steps run
// only the phase division. Stance, zero, unused codes, and steps and evaluate
// while holding stance skip the divider. s_tready rises with m_tvalid. Six
// products share one multiplier. Reset is synchronous and clears the counter,
// the configuration and the handshakes. A result waits in the output register
// while m_tready is low; the next command is still accepted, but its result
// waits until the register is free.
// ----------------------------------------------------------------------------
module leg_gait_trajectory_generator (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,   // gait_index 9:0, forward 10
    input  logic [2:0]                       s_tuser,   // operation 2:0
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [63:0]                      m_tdata,   // hip_abduction_angle 15:0,
                                                        // hip_flexion_angle 31:16,
                                                        // knee_angle 47:32,
                                                        // step_position 57:48,
                                                        // mech_clipped 60:58
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lgt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lgt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lgt_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    lgt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lgt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lgt_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .cmd           (cmd),
        .status        (status),
        .in_op         (s_tuser),
        .in_gait_index (s_tdata[9:0]),
        .in_forward    (s_tdata[10]),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule
